### src/assert_macros.svh
// Assertion macros used by the top module of the glide chain block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every rising clock edge outside reset.
`define ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### src/lgc_pkg.sv
// Package with the field widths and default sizes of the glide chain block.
`default_nettype none

package lgc_pkg;

  // Fixed field widths of the request and result channels.
  localparam int HEIGHT_W = 32;
  localparam int CHAIN_W  = 11;

  // Default sizes of the stores.
  localparam int MAX_ITEMS_DEF   = 1024;
  localparam int HEIGHT_BITS_DEF = 32;

endpackage

`default_nettype wire

### src/lgc_req_if.sv
// Request channel carrying one height and the end-of-sequence mark.
`default_nettype none

interface lgc_req_if;
  logic                          valid;
  logic                          ready;
  logic [lgc_pkg::HEIGHT_W-1:0]  height;
  logic                          last;

  modport source (output valid, output height, output last, input ready);
  modport sink   (input valid, input height, input last, output ready);
endinterface

`default_nettype wire

### src/lgc_rsp_if.sv
// Result channel carrying the longest chain and the overflow flag.
`default_nettype none

interface lgc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lgc_pkg::CHAIN_W-1:0]   longest_chain;
  logic                          overflow;

  modport source (output valid, output longest_chain, output overflow, input ready);
  modport sink   (input valid, input longest_chain, input overflow, output ready);
endinterface

`default_nettype wire

### src/longest_glide_chain_dp_top.sv
// Top level of the glide chain block: load, neighbor passes, sort and chain evaluation.
//
//   channel | dir | payload                   | accepted when
//   req     | in  | height[31:0], last        | req.valid && req.ready
//   rsp     | out | longest_chain[10:0], ovf  | rsp.valid && rsp.ready
//
// Heights load at one per cycle while the block is in its load state.
// After the last request come the two stack passes, one per direction, then the insertion sort
// and the chain pass, each paced by the registered reads of the stores.
// Reset clears the control state only; the stores need no clearing pass.
// A result waiting on rsp holds the next result, and with it the next load, in the done state.
`default_nettype none

module longest_glide_chain_dp_top #(
  parameter int MAX_ITEMS   = lgc_pkg::MAX_ITEMS_DEF,
  parameter int HEIGHT_BITS = lgc_pkg::HEIGHT_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  lgc_req_if.sink    req,
  lgc_rsp_if.source  rsp
);
  import lgc_pkg::*;

  localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int NW = $clog2(MAX_ITEMS + 2);
  localparam int LW = $clog2(MAX_ITEMS + 1);
  localparam int HB = HEIGHT_BITS;

  typedef enum logic [13:0] {
    S_LOAD = 14'b00000000000001,
    S_NRD  = 14'b00000000000010,
    S_NGET = 14'b00000000000100,
    S_NCMP = 14'b00000000001000,
    S_NPOP = 14'b00000000010000,
    S_SRD  = 14'b00000000100000,
    S_SGET = 14'b00000001000000,
    S_SCHK = 14'b00000010000000,
    S_SCMP = 14'b00000100000000,
    S_DRV  = 14'b00001000000000,
    S_DRN  = 14'b00010000000000,
    S_DRC  = 14'b00100000000000,
    S_DWR  = 14'b01000000000000,
    S_DONE = 14'b10000000000000
  } state_t;

  typedef struct packed {
    logic [IW-1:0] idx;
    logic [HB-1:0] h;
  } entry_t;

  // Storage.
  logic [HB-1:0] hmem [MAX_ITEMS];
  entry_t        stk  [MAX_ITEMS];
  logic [NW-1:0] lmem [MAX_ITEMS];
  logic [NW-1:0] rmem [MAX_ITEMS];
  entry_t        vo   [MAX_ITEMS];
  logic [LW-1:0] cmem [MAX_ITEMS + 2];

  state_t        state, state_next;
  logic [CW-1:0] cnt, pos, sp, j;
  logic          ovf, dir;
  logic [IW-1:0] top_idx, p_reg;
  logic [HB-1:0] top_h, cur_h;
  logic          zl, zr;
  logic [LW-1:0] best;
  logic          out_valid;
  logic [CHAIN_W-1:0] out_chain;
  logic          out_ovf;

  // Memory ports.
  logic          h_we, s_we, n_we, v_we, c_we;
  logic [IW-1:0] h_wa, h_ra, s_wa, s_ra, n_wa, n_ra, v_wa, v_ra;
  logic [HB-1:0] h_wd, h_rd;
  entry_t        s_wd, s_rd, v_wd, v_rd;
  logic [NW-1:0] n_wd, l_rd, r_rd;
  logic [NW-1:0] c_wa, c_ra0, c_ra1;
  logic [LW-1:0] c_wd, c_rd0, c_rd1;

  logic [HB+HEIGHT_W-1:0] h_ext;
  logic [IW-1:0]          q;
  logic                   pass_end;
  logic [LW-1:0]          ca, cb, cmax;
  logic [LW+CHAIN_W-1:0]  best_ext;

  always_ff @(posedge clk) begin
    if (h_we) hmem[h_wa] <= h_wd;
    h_rd <= hmem[h_ra];
  end

  always_ff @(posedge clk) begin
    if (s_we) stk[s_wa] <= s_wd;
    s_rd <= stk[s_ra];
  end

  always_ff @(posedge clk) begin
    if (n_we && !dir) lmem[n_wa] <= n_wd;
    if (n_we && dir) rmem[n_wa] <= n_wd;
    l_rd <= lmem[n_ra];
    r_rd <= rmem[n_ra];
  end

  always_ff @(posedge clk) begin
    if (v_we) vo[v_wa] <= v_wd;
    v_rd <= vo[v_ra];
  end

  always_ff @(posedge clk) begin
    if (c_we) cmem[c_wa] <= c_wd;
    c_rd0 <= cmem[c_ra0];
    c_rd1 <= cmem[c_ra1];
  end

  // Position of the current element in a neighbor pass; the right pass runs backward.
  assign q        = dir ? IW'(cnt - pos - 1'b1) : pos[IW-1:0];
  assign pass_end = (CW'(pos + 1'b1) == cnt);
  assign h_ext    = {{HB{1'b0}}, req.height};

  // Chain lengths of the two higher neighbors; the sentinels read as zero.
  assign ca   = zl ? '0 : c_rd0;
  assign cb   = zr ? '0 : c_rd1;
  assign cmax = (ca > cb) ? ca : cb;

  // Memory addressing and write enables.
  always_comb begin
    h_we  = (state == S_LOAD) && req.valid && (cnt < CW'(MAX_ITEMS));
    h_wa  = cnt[IW-1:0];
    h_wd  = h_ext[HB-1:0];
    h_ra  = (state == S_SRD) ? pos[IW-1:0] : q;
    s_we  = 1'b0;
    s_wa  = sp[IW-1:0];
    s_wd  = '{idx: q, h: cur_h};
    s_ra  = IW'(sp - 2'd2);
    n_we  = 1'b0;
    n_wa  = q;
    n_wd  = (sp == '0) ? (dir ? NW'(cnt + 1'b1) : '0) : NW'(top_idx + 1'b1);
    n_ra  = v_rd.idx;
    v_we  = 1'b0;
    v_wa  = j[IW-1:0];
    v_wd  = '{idx: pos[IW-1:0], h: cur_h};
    v_ra  = (state == S_DRV) ? pos[IW-1:0] : IW'(j - 1'b1);
    c_we  = (state == S_DWR);
    c_wa  = NW'(p_reg + 1'b1);
    c_wd  = LW'(cmax + 1'b1);
    c_ra0 = l_rd;
    c_ra1 = r_rd;
    case (state)
      S_NCMP: begin
        if (!(sp != '0 && cur_h >= top_h)) begin
          s_we = 1'b1;
          n_we = 1'b1;
        end
      end
      S_SCHK: begin
        if (j == '0) v_we = 1'b1;
      end
      S_SCMP: begin
        v_we = 1'b1;
        if (v_rd.h < cur_h) v_wd = v_rd;
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: if (req.valid && req.last) state_next = S_NRD;
      S_NRD:  state_next = S_NGET;
      S_NGET: state_next = S_NCMP;
      S_NCMP: begin
        if (sp != '0 && cur_h >= top_h) begin
          if (sp > CW'(1)) state_next = S_NPOP;
        end else if (!pass_end) begin
          state_next = S_NRD;
        end else begin
          state_next = dir ? S_SRD : S_NRD;
        end
      end
      S_NPOP: state_next = S_NCMP;
      S_SRD:  state_next = S_SGET;
      S_SGET: state_next = S_SCHK;
      S_SCHK: begin
        if (j != '0) state_next = S_SCMP;
        else state_next = pass_end ? S_DRV : S_SRD;
      end
      S_SCMP: begin
        if (v_rd.h < cur_h) state_next = S_SCHK;
        else state_next = pass_end ? S_DRV : S_SRD;
      end
      S_DRV:  state_next = S_DRN;
      S_DRN:  state_next = S_DRC;
      S_DRC:  state_next = S_DWR;
      S_DWR:  state_next = pass_end ? S_DONE : S_DRV;
      S_DONE: if (!out_valid) state_next = S_LOAD;
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      cnt       <= '0;
      ovf       <= 1'b0;
      pos       <= '0;
      sp        <= '0;
      dir       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp.ready && out_valid) out_valid <= 1'b0;
      case (state)
        S_LOAD: begin
          if (req.valid) begin
            if (cnt < CW'(MAX_ITEMS)) cnt <= CW'(cnt + 1'b1);
            else ovf <= 1'b1;
            pos <= '0;
            sp  <= '0;
            dir <= 1'b0;
          end
        end
        S_NCMP: begin
          if (sp != '0 && cur_h >= top_h) begin
            sp <= CW'(sp - 1'b1);
          end else if (pass_end) begin
            // The stack empties at the end of each pass.
            pos <= '0;
            sp  <= '0;
            dir <= 1'b1;
          end else begin
            pos <= CW'(pos + 1'b1);
            sp  <= CW'(sp + 1'b1);
          end
        end
        S_SCHK: begin
          if (j == '0) pos <= pass_end ? '0 : CW'(pos + 1'b1);
        end
        S_SCMP: begin
          if (!(v_rd.h < cur_h)) pos <= pass_end ? '0 : CW'(pos + 1'b1);
        end
        S_DWR: begin
          pos <= CW'(pos + 1'b1);
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            cnt       <= '0;
            ovf       <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers without reset.
  assign best_ext = {{CHAIN_W{1'b0}}, best};

  always_ff @(posedge clk) begin
    case (state)
      S_NGET: cur_h <= h_rd;
      S_SGET: begin
        cur_h <= h_rd;
        j     <= pos;
      end
      S_NCMP: begin
        if (!(sp != '0 && cur_h >= top_h)) begin
          top_idx <= q;
          top_h   <= cur_h;
        end
      end
      S_NPOP: begin
        top_idx <= s_rd.idx;
        top_h   <= s_rd.h;
      end
      S_SCMP: begin
        if (v_rd.h < cur_h) j <= CW'(j - 1'b1);
      end
      S_DRN: p_reg <= v_rd.idx;
      S_DRC: begin
        zl <= (l_rd == '0);
        zr <= (r_rd == NW'(cnt + 1'b1));
      end
      S_DWR: begin
        if (LW'(cmax + 1'b1) > best) best <= LW'(cmax + 1'b1);
      end
      S_DONE: begin
        if (!out_valid) begin
          out_chain <= best_ext[CHAIN_W-1:0];
          out_ovf   <= ovf;
        end
      end
      default: begin
      end
    endcase
    if (state == S_SCHK && j == '0 && pass_end) best <= '0;
    if (state == S_SCMP && !(v_rd.h < cur_h) && pass_end) best <= '0;
  end

  assign req.ready         = (state == S_LOAD);
  assign rsp.valid         = out_valid;
  assign rsp.longest_chain = out_chain;
  assign rsp.overflow      = out_ovf;

  `include "assert_macros.svh"

  `ASSERT_NEVER(a_cnt_bound, cnt > CW'(MAX_ITEMS), "item count beyond store depth")
  `ASSERT_NEVER(a_sp_bound, sp > cnt, "stack deeper than the loaded sequence")
  `ASSERT_HOLDS(a_rsp_src, $rose(rsp.valid) |-> $past(state == S_DONE), "result without evaluation")
  `ASSERT_HOLDS(a_load_clr, $rose(rsp.valid) |-> (cnt == '0 && !ovf), "sequence not restarted")

endmodule

`default_nettype wire
